FILE: sv/swvs_pkg.sv
package swvs_pkg;

   localparam int unsigned DEPTH  = 1024;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   localparam logic [46:0] WINDOW_RESET = 47'd60000000000;

   typedef struct packed {
      logic [63:0] ts;
      logic [31:0] qty;
      logic [30:0] prc;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_READ,
      ST_CHECK,
      ST_SUB,
      ST_FIN,
      ST_OUT
   } state_type;

endpackage

FILE: sv/sliding_window_vwap_sums_top.sv
// Sliding time-window price-volume sums. Each trade word (timestamp, quantity, price) gives
// one response word. A trade with zero quantity or a price of zero or below is rejected
// and the response reports the unchanged sums; a trade arriving while all DEPTH slots are
// held is dropped with fifo_full. An accepted trade is written into a single-port trade
// memory and its price times quantity and quantity are added to the saturating sums;
// the oldest stored trades below timestamp minus window_ns are then read back one by one
// and subtracted. A rejected or dropped trade skips the add and eviction steps; for
// each trade it evicts, an accepted trade takes a memory read, a multiply and a
// subtract. One trade is in work at a time; the next trade word is taken while the
// previous response still waits in the output register. The window length may be
// written only while no trade is in work.
module sliding_window_vwap_sums_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [46:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [63:0]        req_timestamp,
   input  logic [31:0]        req_quantity,
   input  logic signed [31:0] req_price,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic               rsp_fifo_full,
   output logic               rsp_sum_overflow,
   output logic [63:0]        rsp_sum_price_volume,
   output logic [63:0]        rsp_sum_volume,
   output logic [10:0]        rsp_trades_in_window,
   output logic               rsp_window_complete
);
   import swvs_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

   slot_type mem [DEPTH];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [63:0]        pv_ff, pv_in, vol_ff, vol_in, first_ff, first_in;
   logic               complete_ff, complete_in;
   logic [46:0]        window_ff;
   logic [63:0]        ts_ff, ts_in, cutoff_ff, cutoff_in;
   logic [31:0]        qty_ff, qty_in;
   logic [62:0]        prod_ff, prod_in;
   logic               ovf_ff, ovf_in, acc_ff, acc_in, full_ff, full_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               mem_we;
   slot_type           rd_ff;
   logic [64:0]        pv_sum, vol_sum;
   logic               accept, reject, load_out;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept  = req_valid && !req_stall;
   assign reject  = (req_quantity == 32'd0) || req_price[31] || (req_price == 32'sd0);
   assign pv_sum  = {1'b0, pv_ff} + {2'b0, prod_ff};
   assign vol_sum = {1'b0, vol_ff} + {33'b0, qty_ff};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      pv_in        = pv_ff;
      vol_in       = vol_ff;
      first_in     = first_ff;
      complete_in  = complete_ff;
      ts_in        = ts_ff;
      qty_in       = qty_ff;
      cutoff_in    = cutoff_ff;
      prod_in      = prod_ff;
      ovf_in       = ovf_ff;
      acc_in       = acc_ff;
      full_in      = full_ff;
      mem_we       = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ts_in     = req_timestamp;
               qty_in    = req_quantity;
               ovf_in    = 1'b0;
               acc_in    = 1'b0;
               full_in   = 1'b0;
               prod_in   = {32'b0, req_price[30:0]} * {31'b0, req_quantity};
               cutoff_in = (req_timestamp > {17'b0, window_ff}) ?
                           req_timestamp - {17'b0, window_ff} : 64'd0;
               if (reject) begin
                  state_in = ST_OUT;
               end else if (count_ff >= FULL_CNT) begin
                  full_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  acc_in   = 1'b1;
                  mem_we   = 1'b1;
                  tail_in  = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            pv_in  = pv_sum[64] ? '1 : pv_sum[63:0];
            vol_in = vol_sum[64] ? '1 : vol_sum[63:0];
            ovf_in = pv_sum[64] || vol_sum[64];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((count_ff != '0) && (rd_ff.ts < cutoff_ff)) begin
               prod_in = {32'b0, rd_ff.prc} * {31'b0, rd_ff.qty};
               if ({32'b0, rd_ff.qty} > vol_ff) begin
                  vol_in = '0;
                  ovf_in = 1'b1;
               end else begin
                  vol_in = vol_ff - {32'b0, rd_ff.qty};
               end
               state_in = ST_SUB;
            end else begin
               if (count_ff == '0) begin
                  pv_in    = '0;
                  vol_in   = '0;
                  first_in = '0;
               end else begin
                  first_in = rd_ff.ts;
               end
               state_in = ST_FIN;
            end
         end
         ST_SUB: begin
            if ({1'b0, prod_ff} > pv_ff) begin
               pv_in  = '0;
               ovf_in = 1'b1;
            end else begin
               pv_in = pv_ff - {1'b0, prod_ff};
            end
            head_in  = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = ST_READ;
         end
         ST_FIN: begin
            if ((ts_ff - first_ff) >= {17'b0, window_ff}) begin
               complete_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pv_ff        <= '0;
         vol_ff       <= '0;
         first_ff     <= '0;
         complete_ff  <= 1'b0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         vol_ff       <= vol_in;
         first_ff     <= first_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ts_ff     <= ts_in;
      qty_ff    <= qty_in;
      cutoff_ff <= cutoff_in;
      prod_ff   <= prod_in;
      ovf_ff    <= ovf_in;
      acc_ff    <= acc_in;
      full_ff   <= full_in;
      if (load_out) begin
         rsp_accepted         <= acc_ff;
         rsp_fifo_full        <= full_ff;
         rsp_sum_overflow     <= ovf_ff;
         rsp_sum_price_volume <= pv_ff;
         rsp_sum_volume       <= vol_ff;
         rsp_trades_in_window <= 11'(count_ff);
         rsp_window_complete  <= complete_ff;
      end
   end

   // trade memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= '{ts: req_timestamp, qty: req_quantity, prc: req_price[30:0]};
      end
      if (state_ff == ST_READ) begin
         rd_ff <= mem[head_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_ptr_empty_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> head_ff == tail_ff)
      else $error("pointers disagree with entry count");

   a_ptr_equal: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (count_ff == '0 || count_ff == FULL_CNT))
      else $error("equal pointers with partial fill");

   a_complete_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(complete_ff))
      else $error("completion flag cleared");

   a_accepted_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_trades_in_window != 11'd0 && !rsp_fifo_full))
      else $error("accepted trade with empty window");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import swvs_pkg::*;

   typedef struct {
      logic [63:0] ts;
      logic [31:0] qty;
      logic [31:0] prc;
   } trade_type;

   typedef struct packed {
      logic        accepted;
      logic        fifo_full;
      logic        overflow;
      logic [63:0] pv;
      logic [63:0] vol;
      logic [10:0] held;
      logic        complete;
   } sums_type;

   localparam logic [63:0] DEFAULT_WINDOW = 64'd60000000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [46:0]        csr_wr_data = '0;
   logic               req_valid = 1'b0;
   wire                req_stall;
   logic [63:0]        req_timestamp = '0;
   logic [31:0]        req_quantity = '0;
   logic signed [31:0] req_price = '0;
   wire                rsp_valid;
   logic               rsp_stall = 1'b0;
   wire                rsp_accepted;
   wire                rsp_fifo_full;
   wire                rsp_sum_overflow;
   wire [63:0]         rsp_sum_price_volume;
   wire [63:0]         rsp_sum_volume;
   wire [10:0]         rsp_trades_in_window;
   wire                rsp_window_complete;

   sliding_window_vwap_sums_top uut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_timestamp        (req_timestamp),
      .req_quantity         (req_quantity),
      .req_price            (req_price),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accepted         (rsp_accepted),
      .rsp_fifo_full        (rsp_fifo_full),
      .rsp_sum_overflow     (rsp_sum_overflow),
      .rsp_sum_price_volume (rsp_sum_price_volume),
      .rsp_sum_volume       (rsp_sum_volume),
      .rsp_trades_in_window (rsp_trades_in_window),
      .rsp_window_complete  (rsp_window_complete)
   );

   always #5 clock = ~clock;

   trade_type   pending_trades[$];
   sums_type    expected_sums[$];
   int          mismatches = 0;
   logic        req_taken = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          send_idle_pct = 20;
   int          stall_idle_pct = 20;
   logic        calm = 1'b0;
   logic [63:0] clock_ns = '0;

   // window state as the block should hold it
   slot_type    trade_mem [DEPTH];
   int unsigned head_idx = 0;
   int unsigned tail_idx = 0;
   logic [10:0] held_count = '0;
   logic [63:0] pv_total = '0;
   logic [63:0] vol_total = '0;
   logic [63:0] oldest_ts = '0;
   logic        complete_seen = 1'b0;
   logic [46:0] window_len = WINDOW_RESET;
   logic        step_overflow = 1'b0;

   function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total[64]) begin
         step_overflow = 1'b1;
         return '1;
      end
      return total[63:0];
   endfunction

   function automatic logic [63:0] clamp_sub(logic [63:0] a, logic [63:0] b);
      if (b > a) begin
         step_overflow = 1'b1;
         return '0;
      end
      return a - b;
   endfunction

   function automatic logic [63:0] slot_product(slot_type s);
      logic [63:0] p;
      logic [63:0] q;
      p = s.prc;
      q = s.qty;
      return p * q;
   endfunction

   function automatic void update_window_sums(trade_type t);
      slot_type    s;
      logic [63:0] cutoff;
      logic [63:0] span;
      sums_type    w;
      step_overflow = 1'b0;
      if (t.qty == 0 || t.prc == 0 || t.prc[31]) begin
         w = '{1'b0, 1'b0, 1'b0, pv_total, vol_total, held_count, complete_seen};
      end else if (held_count >= DEPTH) begin
         w = '{1'b0, 1'b1, 1'b0, pv_total, vol_total, held_count, complete_seen};
      end else begin
         s = '{t.ts, t.qty, t.prc[30:0]};
         trade_mem[tail_idx] = s;
         tail_idx = (tail_idx + 1) % DEPTH;
         held_count = held_count + 1;
         pv_total = clamp_add(pv_total, slot_product(s));
         vol_total = clamp_add(vol_total, {32'b0, t.qty});
         cutoff = (t.ts > {17'b0, window_len}) ? t.ts - {17'b0, window_len} : '0;
         while (held_count != 0 && trade_mem[head_idx].ts < cutoff) begin
            pv_total = clamp_sub(pv_total, slot_product(trade_mem[head_idx]));
            vol_total = clamp_sub(vol_total, {32'b0, trade_mem[head_idx].qty});
            head_idx = (head_idx + 1) % DEPTH;
            held_count = held_count - 1;
         end
         if (held_count == 0) begin
            pv_total = '0;
            vol_total = '0;
            oldest_ts = '0;
         end else begin
            oldest_ts = trade_mem[head_idx].ts;
         end
         span = t.ts - oldest_ts;
         if (span >= {17'b0, window_len})
            complete_seen = 1'b1;
         w = '{1'b1, 1'b0, step_overflow, pv_total, vol_total, held_count, complete_seen};
      end
      expected_sums.insert(expected_sums.size(), w);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic push_trade(logic [63:0] ts, logic [31:0] qty, logic [31:0] prc);
      trade_type t;
      t.ts = ts;
      t.qty = qty;
      t.prc = prc;
      pending_trades.insert(pending_trades.size(), t);
   endtask

   // out-of-order, jumps past the window, repeated times and plain steps
   task automatic queue_random_trades(int count, logic [63:0] step_max, int reject_pct,
                                      int jump_pct, int big_pct);
      logic [63:0] back;
      logic [63:0] ts;
      logic [31:0] qty;
      logic [31:0] prc;
      logic [31:0] r;
      int          pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            back = rand64() % (step_max + 1);
            ts = (back > clock_ns) ? '0 : clock_ns - back;
         end else if (pick < 5 + jump_pct) begin
            clock_ns = clock_ns + {17'b0, window_len} + rand64() % (step_max + 1) + 1;
            ts = clock_ns;
         end else if (pick < 20 + jump_pct) begin
            ts = clock_ns;
         end else begin
            clock_ns = clock_ns + rand64() % (step_max + 1);
            ts = clock_ns;
         end
         if ($urandom_range(99) >= big_pct)
            qty = $urandom_range(1, 1000);
         else if ($urandom_range(3) == 0)
            qty = '1;
         else
            qty = $urandom;
         if (qty == 0)
            qty = 1;
         r = $urandom;
         if ($urandom_range(99) >= big_pct)
            prc = $urandom_range(1, 100000);
         else if ($urandom_range(3) == 0)
            prc = 32'h7FFF_FFFF;
         else
            prc = {1'b0, r[30:0]};
         if (prc == 0)
            prc = 1;
         if ($urandom_range(99) < reject_pct) begin
            case ($urandom_range(2))
               0: begin
                  qty = '0;
               end
               1: begin
                  prc = '0;
               end
               default: begin
                  prc = {1'b1, r[30:0]};
               end
            endcase
         end
         push_trade(ts, qty, prc);
      end
   endtask

   task automatic wait_idle();
      while (pending_trades.size() != 0 || req_valid || expected_sums.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_window(logic [46:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      window_len = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      send_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
      stall_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
   endtask

   // trade words onto the request port
   always @(negedge clock) begin : drive_trades
      trade_type t;
      logic      next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_trades.size() != 0) begin
            t = pending_trades[0];
            pending_trades.delete(0);
            req_timestamp <= t.ts;
            req_quantity <= t.qty;
            req_price <= t.prc;
            next_valid = 1'b1;
            if (!calm && $urandom_range(99) < send_idle_pct)
               send_gap = $urandom_range(1, 11);
         end
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < stall_idle_pct) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watch_ports
      trade_type t;
      sums_type  w;
      logic      fire;
      fire = !reset && req_valid && req_stall === 1'b0;
      req_taken <= fire;
      if (fire) begin
         t.ts = req_timestamp;
         t.qty = req_quantity;
         t.prc = req_price;
         update_window_sums(t);
      end
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: response word with no trade waiting", $time);
            mismatches++;
         end else begin
            w = expected_sums[0];
            expected_sums.delete(0);
            check_field("accepted", w.accepted, rsp_accepted);
            check_field("fifo_full", w.fifo_full, rsp_fifo_full);
            check_field("sum_overflow", w.overflow, rsp_sum_overflow);
            check_field("sum_price_volume", w.pv, rsp_sum_price_volume);
            check_field("sum_volume", w.vol, rsp_sum_volume);
            check_field("trades_in_window", w.held, rsp_trades_in_window);
            check_field("window_complete", w.complete, rsp_window_complete);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [63:0] r;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // rejects: zero quantity, zero price, negative prices
      push_trade(64'd0, 32'd0, 32'd5);
      push_trade(64'd0, 32'd7, 32'd0);
      push_trade(64'd0, 32'd7, 32'hFFFF_FFFF);
      push_trade('1, '1, 32'h8000_0000);
      // early window, then largest products until the sum saturates
      push_trade(64'd0, 32'd1, 32'd1);
      push_trade(64'd1, '1, 32'h7FFF_FFFF);
      push_trade(64'd2, '1, 32'h7FFF_FFFF);
      push_trade(64'd3, '1, 32'h7FFF_FFFF);
      // evicting the saturated trades runs the sum below zero
      push_trade(DEFAULT_WINDOW + 10, 32'd5, 32'd7);
      push_trade(2 * DEFAULT_WINDOW + 10, 32'd1, 32'd1);
      // older timestamp than the stored ones
      push_trade(64'd5, 32'd3, 32'd100);
      push_trade(10 * DEFAULT_WINDOW, 32'd2, 32'd2);
      push_trade(10 * DEFAULT_WINDOW, 32'd9, 32'd1);
      push_trade(10 * DEFAULT_WINDOW, 32'd4, 32'hFFFF_FFFB);
      clock_ns = 10 * DEFAULT_WINDOW;

      write_window(47'd0);
      queue_random_trades(20, 64'd3, 15, 3, 30);
      write_window(47'd1);
      queue_random_trades(20, 64'd3, 15, 3, 30);
      r = rand64();
      write_window(r[46:0]);
      queue_random_trades(40, {17'b0, window_len} >> 2, 10, 3, 40);
      write_window(WINDOW_RESET);
      queue_random_trades(40, {17'b0, window_len} >> 2, 10, 3, 40);
      // widest window: the store fills up and further trades are dropped
      write_window('1);
      queue_random_trades(1070, 64'd1000, 2, 0, 20);
      // short window: one trade flushes the whole store
      write_window(47'd1000);
      calm = 1'b1;
      clock_ns = clock_ns + 64'd1000000;
      push_trade(clock_ns, 32'd1, 32'd1);
      queue_random_trades(60, 64'd3000, 10, 3, 40);

      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
